// ===== design/slrg_pkg.sv =====
package slrg_pkg;

  typedef logic [29:0] word_t;
  typedef logic [5:0]  idx_t;

  localparam word_t MOD_BIG        = 30'd1000000000;
  localparam logic [27:0] SEED_BIG = 28'd161803398;
  localparam int    TABLE_LEN_I    = 55;
  localparam int    MIX_OFFSET_I   = 30;
  localparam idx_t  TABLE_LEN      = 6'(TABLE_LEN_I);
  localparam idx_t  SCATTER_STEP   = 6'd21;
  localparam idx_t  TRAIL_START    = 6'd31;
  localparam idx_t  TABLE_DEPTH    = 6'd56;
  localparam logic [1:0] LAST_PASS = 2'd3;
  localparam idx_t  MIX_SLOT_START = 6'(1 + (1 + MIX_OFFSET_I) % TABLE_LEN_I);

  // a - b wrapped into 0 .. MOD_BIG-1; both operands below MOD_BIG
  function automatic word_t sub_wrap(input word_t a, input word_t b);
    logic [30:0] sum;
    begin
      sum = {1'b0, a} + {1'b0, MOD_BIG} - {1'b0, b};
      if (a >= b) begin
        sub_wrap = a - b;
      end else begin
        sub_wrap = sum[29:0];
      end
    end
  endfunction

  // advance a table index, wrapping from the table depth back to one
  function automatic idx_t wrap_idx(input idx_t i);
    logic [6:0] inc;
    begin
      inc = {1'b0, i} + 7'd1;
      if (inc >= {1'b0, TABLE_DEPTH}) begin
        wrap_idx = 6'd1;
      end else begin
        wrap_idx = inc[5:0];
      end
    end
  endfunction

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wdata;
    logic  re;
    idx_t  raddr_a;
    idx_t  raddr_b;
  } ram_ctrl_t;

endpackage

// ===== design/slrg_lag_ram.sv =====
module slrg_lag_ram (
  input  logic              clk,
  input  slrg_pkg::ram_ctrl_t ctrl,
  output slrg_pkg::word_t   rdata_a,
  output slrg_pkg::word_t   rdata_b
);
  import slrg_pkg::*;

  word_t mem [0:55];

  // one write port, two registered read ports, old data on collision
  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.waddr] <= ctrl.wdata;
    end
    if (ctrl.re) begin
      rdata_a <= mem[ctrl.raddr_a];
      rdata_b <= mem[ctrl.raddr_b];
    end
  end

endmodule

// ===== design/subtractive_lagged_random_generator_core.sv =====
// Subtractive lagged random generator with a biased coin output.
// Input channel (in_valid/in_ready): op, seed_magnitude, coin_limit.
// Output channel (out_valid/out_ready): value (0..999999999) and coin.
// Each accepted word gives exactly one output word.
// The lag table sits in a 56-entry RAM with one write port and two
// registered read ports. A plain item reads the lead and trail entries in
// ST_GEN_RD and writes the difference back in ST_GEN_WR once the output
// register is free, which also registers the output word. A new word is
// accepted only after the previous one has reached the output register.
// A reseed (op = 1, or the first word after reset) first rebuilds the
// table: 55 scattered fills (one RAM write a cycle), then 4 x 55 mixing
// steps pipelined one a cycle, the last write-back overlapping the
// generate read.
// Reset clears the control state; the table contents stay undefined until
// the first rebuild, which reset forces.
// A stalled receiver holds the output register; the next item is still
// accepted and computed, and waits for the register before writing back.
module subtractive_lagged_random_generator_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   op,
  input  logic [27:0]            seed_magnitude,
  input  logic [29:0]            coin_limit,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [29:0]            value,
  output logic                   coin
);
  import slrg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCATTER,
    ST_MIX,
    ST_GEN_RD,
    ST_GEN_WR
  } state_t;

  state_t      state;
  logic        seeded;
  idx_t        lead;
  idx_t        trail;
  logic [29:0] limit;
  word_t       cur;
  word_t       nxt;
  idx_t        slot;
  idx_t        cnt;
  idx_t        mix_i;
  logic [1:0]  pass;
  logic        mix_pend;
  idx_t        mix_waddr;
  ram_ctrl_t   ram_ctrl;
  word_t       rdata_a;
  word_t       rdata_b;
  word_t       gen_val;
  logic        out_free;
  logic        mix_last;
  logic [27:0] seed_sat;
  logic [6:0]  slot_sum;
  idx_t        slot_next;
  idx_t        lead_next;
  idx_t        trail_next;

  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign gen_val   = sub_wrap(rdata_a, rdata_b);
  assign mix_last  = (pass == LAST_PASS) && (mix_i == TABLE_LEN);
  assign seed_sat  = (seed_magnitude > SEED_BIG) ? SEED_BIG : seed_magnitude;
  assign slot_sum  = {1'b0, slot} + {1'b0, SCATTER_STEP};
  assign slot_next = (slot_sum >= {1'b0, TABLE_LEN}) ? 6'(slot_sum - {1'b0, TABLE_LEN})
                                                     : slot_sum[5:0];
  assign lead_next  = wrap_idx(lead);
  assign trail_next = wrap_idx(trail);

  // drive the RAM ports from the current phase
  always_comb begin
    ram_ctrl = '0;
    if (mix_pend) begin
      ram_ctrl.we    = 1'b1;
      ram_ctrl.waddr = mix_waddr;
      ram_ctrl.wdata = gen_val;
    end else if (state == ST_SCATTER) begin
      ram_ctrl.we = 1'b1;
      if (cnt == '0) begin
        ram_ctrl.waddr = TABLE_LEN;
        ram_ctrl.wdata = cur;
      end else begin
        ram_ctrl.waddr = slot;
        ram_ctrl.wdata = nxt;
      end
    end else if (state == ST_GEN_WR) begin
      ram_ctrl.we    = out_free;
      ram_ctrl.waddr = lead;
      ram_ctrl.wdata = gen_val;
    end
    case (state)
      ST_MIX: begin
        ram_ctrl.re      = 1'b1;
        ram_ctrl.raddr_a = mix_i;
        ram_ctrl.raddr_b = slot;
      end
      ST_GEN_RD: begin
        ram_ctrl.re      = 1'b1;
        ram_ctrl.raddr_a = lead_next;
        ram_ctrl.raddr_b = trail_next;
      end
      default: begin
        ram_ctrl.re = 1'b0;
      end
    endcase
  end

  slrg_lag_ram u_ram (
    .clk     (clk),
    .ctrl    (ram_ctrl),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // sequencer: accept, rebuild, generate, present
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seeded    <= 1'b0;
      lead      <= '0;
      trail     <= TRAIL_START;
      out_valid <= 1'b0;
      mix_pend  <= 1'b0;
      cnt       <= '0;
      pass      <= '0;
    end else begin
      // drop the output word once taken
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      mix_pend  <= 1'b0;
      mix_waddr <= mix_i;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            limit <= coin_limit;
            if (op || !seeded) begin
              state <= ST_SCATTER;
              cur   <= {2'b00, SEED_BIG - seed_sat};
              nxt   <= 30'd1;
              slot  <= SCATTER_STEP;
              cnt   <= '0;
            end else begin
              state <= ST_GEN_RD;
            end
          end
        end
        ST_SCATTER: begin
          cnt <= cnt + 6'd1;
          if (cnt != '0) begin
            nxt  <= sub_wrap(cur, nxt);
            cur  <= nxt;
            slot <= slot_next;
          end
          if (cnt == TABLE_LEN - 6'd1) begin
            state <= ST_MIX;
            mix_i <= 6'd1;
            slot  <= MIX_SLOT_START;
            pass  <= '0;
          end
        end
        ST_MIX: begin
          // issue one read a cycle; the write lands the cycle after
          mix_pend <= 1'b1;
          if (mix_i == TABLE_LEN) begin
            mix_i <= 6'd1;
            pass  <= pass + 2'd1;
          end else begin
            mix_i <= mix_i + 6'd1;
          end
          slot <= (slot == TABLE_LEN) ? 6'd1 : slot + 6'd1;
          if (mix_last) begin
            state  <= ST_GEN_RD;
            lead   <= '0;
            trail  <= TRAIL_START;
            seeded <= 1'b1;
          end
        end
        ST_GEN_RD: begin
          lead  <= lead_next;
          trail <= trail_next;
          state <= ST_GEN_WR;
        end
        ST_GEN_WR: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            value     <= gen_val;
            coin      <= (gen_val <= limit);
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
